[design/tcw_pkg.sv]
// Package for the text console writer: action codes, control bytes, field widths.
// No dependencies. Used by text_console_writer_top, tcw_checker and the testbench.
package tcw_pkg;

   localparam int ACTION_W    = 2;
   localparam int CHAR_W      = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int LIN_FIELD_W = 11;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

   // tab stops every TAB_STEP columns
   localparam int TAB_STEP = 4;

endpackage

[design/tcw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/text_console_writer_top.sv]
// Text console writer: character screen store, cursor and put/clear/read sequencer.
// Depends on tcw_pkg and tcw_ram.
//
//   channel | ports                       | dir | beat
//   req     | req_valid/req_ready + fields | in  | action, char_code, read_row, read_col
//   rsp     | rsp_valid/rsp_ready + fields | out | cursor_row/col/linear, cell_char
//
// Plain put, control code or read: the result is registered after S_EXEC and S_DONE
// (an in-range read also passes S_RD_WAIT); req_ready returns together with rsp_valid.
// Scroll: one store port pair walked by a single address counter; each moved cell is
// read in S_SCR_RD and written in S_SCR_WR, then S_BLANK blanks the bottom row.
// Clear: S_BLANK writes a blank to every cell. After reset the same blanking pass runs
// in S_INIT with req_ready low.
// A stalled result holds in the output register; the next beat is taken meanwhile
// and its result waits until the register frees.
module text_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tcw_pkg::ACTION_W-1:0]        req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]          req_char_code,
   input  logic [tcw_pkg::ROW_FIELD_W-1:0]     req_read_row,
   input  logic [tcw_pkg::COL_FIELD_W-1:0]     req_read_col,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tcw_pkg::ROW_FIELD_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::COL_FIELD_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::LIN_FIELD_W-1:0]     rsp_cursor_linear,
   output logic [tcw_pkg::CHAR_W-1:0]          rsp_cell_char
);

   localparam int Cells    = ROWS * COLUMNS;
   localparam int AddrW    = $clog2(Cells);
   localparam int RowW     = $clog2(ROWS);
   localparam int ColW     = $clog2(COLUMNS);
   localparam int RowNW    = RowW + 1;
   localparam int ColNW    = ColW + 1;
   localparam int LastBase = (ROWS - 1) * COLUMNS;
   localparam int RowFW    = tcw_pkg::ROW_FIELD_W;
   localparam int ColFW    = tcw_pkg::COL_FIELD_W;
   localparam int LinFW    = tcw_pkg::LIN_FIELD_W;
   localparam int CharW    = tcw_pkg::CHAR_W;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_RD_WAIT,
      S_SCR_RD,
      S_SCR_WR,
      S_BLANK,
      S_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [RowW-1:0]                row_ff, row_in;
   logic [ColW-1:0]                col_ff, col_in;
   logic [AddrW-1:0]               addr_ff, addr_in;
   logic [tcw_pkg::ACTION_W-1:0]   act_ff, act_in;
   logic [CharW-1:0]               char_ff, char_in;
   logic [RowFW-1:0]               rd_row_ff, rd_row_in;
   logic [ColFW-1:0]               rd_col_ff, rd_col_in;
   logic [CharW-1:0]               cell_ff, cell_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RowFW-1:0]               rsp_row_ff, rsp_row_in;
   logic [ColFW-1:0]               rsp_col_ff, rsp_col_in;
   logic [LinFW-1:0]               rsp_lin_ff, rsp_lin_in;
   logic [CharW-1:0]               rsp_cell_ff, rsp_cell_in;

   // shared position-to-address unit
   logic [RowW-1:0]                mul_row;
   logic [ColW-1:0]                mul_col;
   logic [AddrW-1:0]               lin;

   logic                           ram_we;
   logic [AddrW-1:0]               ram_waddr;
   logic [CharW-1:0]               ram_wdata;
   logic [AddrW-1:0]               ram_raddr;
   logic [CharW-1:0]               ram_rdata;

   logic [RowNW-1:0]               rn;
   logic [ColNW-1:0]               cn;
   logic [ColNW-1:0]               tab_sum;
   logic                           req_beat;

   assign lin = AddrW'(AddrW'(mul_row) * AddrW'(COLUMNS)) + AddrW'(mul_col);
   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign tab_sum   = ColNW'(col_ff) + ColNW'(tcw_pkg::TAB_STEP);

   tcw_ram #(
      .WIDTH(CharW),
      .DEPTH(Cells)
   ) u_screen (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      addr_in      = addr_ff;
      act_in       = act_ff;
      char_in      = char_ff;
      rd_row_in    = rd_row_ff;
      rd_col_in    = rd_col_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_cell_in  = rsp_cell_ff;
      mul_row      = row_ff;
      mul_col      = col_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = tcw_pkg::CHAR_BLANK;
      ram_raddr    = addr_ff;
      rn           = RowNW'(row_ff);
      cn           = ColNW'(col_ff);

      unique case (state_ff)
         S_INIT, S_BLANK: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + AddrW'(1);
            if (addr_ff == AddrW'(Cells - 1)) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               act_in    = req_action;
               char_in   = req_char_code;
               rd_row_in = req_read_row;
               rd_col_in = req_read_col;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cell_in  = '0;
            state_in = S_DONE;
            unique case (act_ff)
               tcw_pkg::ACT_PUT: begin
                  priority if (char_ff == tcw_pkg::CHAR_BS) begin
                     if (col_ff != '0) begin
                        cn = ColNW'(col_ff) - ColNW'(1);
                     end else begin
                        if (row_ff != '0) rn = RowNW'(row_ff) - RowNW'(1);
                        cn = ColNW'(COLUMNS - 1);
                     end
                     mul_row   = RowW'(rn);
                     mul_col   = ColW'(cn);
                     ram_we    = 1'b1;
                     ram_wdata = tcw_pkg::CHAR_BLANK;
                  end else if (char_ff == tcw_pkg::CHAR_TAB) begin
                     cn = {tab_sum[ColNW-1:2], 2'b00};
                  end else if (char_ff == tcw_pkg::CHAR_CR) begin
                     cn = '0;
                  end else if (char_ff == tcw_pkg::CHAR_LF) begin
                     cn = '0;
                     rn = RowNW'(row_ff) + RowNW'(1);
                  end else if (!char_ff[CharW-1] && char_ff >= tcw_pkg::CHAR_BLANK) begin
                     ram_we    = 1'b1;
                     ram_wdata = char_ff;
                     cn        = ColNW'(col_ff) + ColNW'(1);
                  end else begin
                     cn = ColNW'(col_ff);
                  end
                  ram_waddr = lin;
                  // wrap past last column
                  if (cn >= ColNW'(COLUMNS)) begin
                     cn = '0;
                     rn = rn + RowNW'(1);
                  end
                  // ran off the bottom: scroll, cursor stays on last row
                  if (rn >= RowNW'(ROWS)) begin
                     rn       = RowNW'(ROWS - 1);
                     addr_in  = '0;
                     state_in = S_SCR_RD;
                  end
                  row_in = RowW'(rn);
                  col_in = ColW'(cn);
               end
               tcw_pkg::ACT_CLEAR: begin
                  row_in   = '0;
                  col_in   = '0;
                  addr_in  = '0;
                  state_in = S_BLANK;
               end
               tcw_pkg::ACT_READ: begin
                  mul_row   = RowW'(rd_row_ff);
                  mul_col   = ColW'(rd_col_ff);
                  ram_raddr = lin;
                  if (int'(rd_row_ff) < ROWS && int'(rd_col_ff) < COLUMNS) begin
                     state_in = S_RD_WAIT;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RD_WAIT: begin
            cell_in  = ram_rdata;
            state_in = S_DONE;
         end
         S_SCR_RD: begin
            ram_raddr = addr_ff + AddrW'(COLUMNS);
            state_in  = S_SCR_WR;
         end
         S_SCR_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            addr_in   = addr_ff + AddrW'(1);
            // last moved cell: blank the bottom row next
            state_in  = (addr_ff == AddrW'(LastBase - 1)) ? S_BLANK : S_SCR_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = RowFW'(row_ff);
               rsp_col_in   = ColFW'(col_ff);
               rsp_lin_in   = LinFW'(lin);
               rsp_cell_in  = cell_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      char_ff     <= char_in;
      rd_row_ff   <= rd_row_in;
      rd_col_ff   <= rd_col_in;
      cell_ff     <= cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_lin_ff  <= rsp_lin_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_cell_char     = rsp_cell_ff;

endmodule

[design/tcw_checker.sv]
// Port-level checks for text_console_writer_top, attached by bind.
// Depends on tcw_pkg.
module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tcw_pkg::ROW_FIELD_W-1:0] rsp_cursor_row,
   input logic [tcw_pkg::COL_FIELD_W-1:0] rsp_cursor_col,
   input logic [tcw_pkg::LIN_FIELD_W-1:0] rsp_cursor_linear,
   input logic [tcw_pkg::CHAR_W-1:0]      rsp_cell_char
);

   localparam int LinFW = tcw_pkg::LIN_FIELD_W;

   // stalled result beat holds (valid, linear cursor, cell char and row)
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_linear)
         && $stable(rsp_cell_char) && $stable(rsp_cursor_row))
      else $error("result beat changed while stalled");

   // one item at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a beat while busy");

   a_linear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_linear
         == LinFW'(int'(rsp_cursor_row) * COLUMNS + int'(rsp_cursor_col)))
      else $error("linear cursor does not match row and column");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_row) < ROWS && int'(rsp_cursor_col) < COLUMNS)
      else $error("cursor out of screen");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind text_console_writer_top tcw_checker #(
   .COLUMNS(COLUMNS),
   .ROWS   (ROWS)
) u_tcw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_cursor_row   (rsp_cursor_row),
   .rsp_cursor_col   (rsp_cursor_col),
   .rsp_cursor_linear(rsp_cursor_linear),
   .rsp_cell_char    (rsp_cell_char)
);

[test/tb_text_console_writer_top.sv]
// Self-checking testbench for text_console_writer_top: directed and random put/clear/read
// beats, checked against an in-bench screen/cursor model. Depends on tcw_pkg and the RTL.
module tb_text_console_writer_top;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int RANDOM_ITEMS = 850;
   localparam int MAX_WAIT     = 18;
   localparam int DRAIN_EVERY  = 200;

   localparam int ACTION_W    = tcw_pkg::ACTION_W;
   localparam int CHAR_W      = tcw_pkg::CHAR_W;
   localparam int ROW_FIELD_W = tcw_pkg::ROW_FIELD_W;
   localparam int COL_FIELD_W = tcw_pkg::COL_FIELD_W;
   localparam int LIN_FIELD_W = tcw_pkg::LIN_FIELD_W;
   localparam int TAB_STEP    = tcw_pkg::TAB_STEP;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [CHAR_W-1:0]   CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0]   CHAR_LAST  = 8'h7F;
   localparam logic [CHAR_W-1:0]   CHAR_HIGH  = 8'h80;
   localparam logic [CHAR_W-1:0]   CHAR_MAX   = 8'hFF;

   typedef struct {
      logic [ACTION_W-1:0]    action;
      logic [CHAR_W-1:0]      ch;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      bit                     drain_first;
   } console_req_type;

   typedef struct {
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] col;
      logic [LIN_FIELD_W-1:0] lin;
      logic [CHAR_W-1:0]      cell_char;
   } cursor_view_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [ACTION_W-1:0]    req_action;
   logic [CHAR_W-1:0]      req_char_code;
   logic [ROW_FIELD_W-1:0] req_read_row;
   logic [COL_FIELD_W-1:0] req_read_col;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [ROW_FIELD_W-1:0] rsp_cursor_row;
   logic [COL_FIELD_W-1:0] rsp_cursor_col;
   logic [LIN_FIELD_W-1:0] rsp_cursor_linear;
   logic [CHAR_W-1:0]      rsp_cell_char;

   text_console_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_col      (req_read_col),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_linear (rsp_cursor_linear),
      .rsp_cell_char     (rsp_cell_char)
   );

   // screen model and cursor
   logic [CHAR_W-1:0] screen_model [CELLS];
   int unsigned       model_row;
   int unsigned       model_col;

   console_req_type pending_q [$];
   cursor_view_type cursor_expect_q [$];
   console_req_type next_beat;

   int  counted_items;
   bit  drain_pending;
   int  gap_left;
   int  stall_left;
   bit  req_taken;
   bit  send_burst;
   bit  recv_burst;
   int  mismatch_count;
   int  result_count;
   int  put_count, clear_count, read_count, scroll_count, odd_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic add_item(logic [ACTION_W-1:0] action, logic [CHAR_W-1:0] ch,
                           logic [ROW_FIELD_W-1:0] row, logic [COL_FIELD_W-1:0] col);
      console_req_type it;
      it.action      = action;
      it.ch          = ch;
      it.row         = row;
      it.col         = col;
      it.drain_first = drain_pending;
      drain_pending  = 1'b0;
      pending_q.push_back(it);
      counted_items++;
   endtask

   task automatic add_put(logic [CHAR_W-1:0] ch);
      add_item(tcw_pkg::ACT_PUT, ch, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
   endtask

   task automatic add_read(int unsigned row, int unsigned col);
      add_item(tcw_pkg::ACT_READ, CHAR_W'($urandom), ROW_FIELD_W'(row), COL_FIELD_W'(col));
   endtask

   function automatic void scroll_screen();
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
         screen_model[i] = screen_model[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
         screen_model[i] = tcw_pkg::CHAR_BLANK;
      model_row = ROWS - 1;
      scroll_count++;
   endfunction

   function automatic void put_char(logic [CHAR_W-1:0] ch);
      int unsigned r, c;
      r = model_row;
      c = model_col;
      if (ch == tcw_pkg::CHAR_BS) begin
         if (c > 0) c--;
         else begin
            if (r > 0) r--;
            c = COLUMNS - 1;
         end
         screen_model[r * COLUMNS + c] = tcw_pkg::CHAR_BLANK;
      end else if (ch == tcw_pkg::CHAR_TAB) begin
         c = (c + TAB_STEP) & ~(TAB_STEP - 1);
      end else if (ch == tcw_pkg::CHAR_CR) begin
         c = 0;
      end else if (ch == tcw_pkg::CHAR_LF) begin
         c = 0;
         r++;
      end else if (ch >= tcw_pkg::CHAR_BLANK && ch <= CHAR_LAST) begin
         screen_model[r * COLUMNS + c] = ch;
         c++;
      end
      if (c >= COLUMNS) begin
         c = 0;
         r++;
      end
      model_row = r;
      model_col = c;
      if (model_row >= ROWS) scroll_screen();
   endfunction

   function automatic cursor_view_type console_predict(console_req_type it);
      cursor_view_type v;
      logic [CHAR_W-1:0] cell_val;
      cell_val = '0;
      if (it.action == tcw_pkg::ACT_PUT) begin
         put_count++;
         put_char(it.ch);
      end else if (it.action == tcw_pkg::ACT_CLEAR) begin
         clear_count++;
         for (int i = 0; i < CELLS; i++) screen_model[i] = tcw_pkg::CHAR_BLANK;
         model_row = 0;
         model_col = 0;
      end else if (it.action == tcw_pkg::ACT_READ) begin
         read_count++;
         if (it.row < ROWS && it.col < COLUMNS)
            cell_val = screen_model[it.row * COLUMNS + it.col];
      end else begin
         odd_count++;
      end
      v.row       = ROW_FIELD_W'(model_row);
      v.col       = COL_FIELD_W'(model_col);
      v.lin       = LIN_FIELD_W'(model_row * COLUMNS + model_col);
      v.cell_char = cell_val;
      return v;
   endfunction

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      $display("mismatch in %s at result %0d: got %0d, expected %0d", field, result_count,
               got, want);
      mismatch_count++;
   endtask

   // driver: presents beats at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // beat still waiting to be taken: hold
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain_first && cursor_expect_q.size() > 0)) begin
         next_beat     = pending_q.pop_front();
         req_action    <= next_beat.action;
         req_char_code <= next_beat.ch;
         req_read_row  <= next_beat.row;
         req_read_col  <= next_beat.col;
         req_valid     <= 1'b1;
         if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
         gap_left <= draw_wait(send_burst);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else rsp_ready <= 1'b1;
   end

   // monitor: check results first, then predict for the beat taken at this edge
   always @(posedge clock) begin
      cursor_view_type exp_view;
      console_req_type taken;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (cursor_expect_q.size() == 0) begin
               report_mismatch("result beats outstanding", 0, 1);
            end else begin
               exp_view = cursor_expect_q.pop_front();
               if (rsp_cursor_row !== exp_view.row)
                  report_mismatch("cursor_row", rsp_cursor_row, exp_view.row);
               if (rsp_cursor_col !== exp_view.col)
                  report_mismatch("cursor_col", rsp_cursor_col, exp_view.col);
               if (rsp_cursor_linear !== exp_view.lin)
                  report_mismatch("cursor_linear", rsp_cursor_linear, exp_view.lin);
               if (rsp_cell_char !== exp_view.cell_char)
                  report_mismatch("cell_char", rsp_cell_char, exp_view.cell_char);
            end
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
            stall_left <= draw_wait(recv_burst);
         end
         if (req_valid && req_ready) begin
            taken.action      = req_action;
            taken.ch          = req_char_code;
            taken.row         = req_read_row;
            taken.col         = req_read_col;
            taken.drain_first = 1'b0;
            cursor_expect_q.push_back(console_predict(taken));
         end
      end
   end

   // worst case is a scroll per beat plus full stalls, several times over
   initial begin
      #60_000_000;
      $display("timeout with %0d results outstanding", cursor_expect_q.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int sel, len, r, tail, next_drain_at;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = tcw_pkg::ACT_PUT;
      req_char_code = '0;
      req_read_row  = '0;
      req_read_col  = '0;
      rsp_ready     = 1'b0;
      gap_left      = 0;
      stall_left    = 0;
      req_taken     = 1'b0;
      send_burst    = 1'b0;
      recv_burst    = 1'b0;
      drain_pending = 1'b0;
      for (int i = 0; i < CELLS; i++) screen_model[i] = tcw_pkg::CHAR_BLANK;
      model_row = 0;
      model_col = 0;

      // directed: field extremes, every control code, both backspace branches,
      // wrap by a printable and by a tab, out-of-range reads, unused action
      add_read(0, 0);
      add_put(8'h41);
      add_put(CHAR_LAST);
      add_put(tcw_pkg::CHAR_BLANK);
      add_put(CHAR_NUL);
      add_put(CHAR_HIGH);
      add_put(CHAR_MAX);
      add_put(tcw_pkg::CHAR_TAB);
      add_put(tcw_pkg::CHAR_BS);
      add_read(0, 1);
      add_put(tcw_pkg::CHAR_CR);
      add_put(tcw_pkg::CHAR_LF);
      add_put(tcw_pkg::CHAR_BS);   // column 0 on row 1: back to row 0, last column
      add_put(8'h5A);              // printable in last column wraps
      add_put(tcw_pkg::CHAR_BS);
      add_put(tcw_pkg::CHAR_TAB);  // tab from last column wraps
      add_item(ACT_UNUSED, 8'h55, 5'd31, 7'd127);
      add_read(31, 127);
      add_read(ROWS - 1, COLUMNS - 1);
      add_read(0, COLUMNS);
      add_read(ROWS, 0);
      add_item(tcw_pkg::ACT_CLEAR, CHAR_MAX, 5'd31, 7'd127);
      add_put(tcw_pkg::CHAR_BS);   // column 0 on row 0 stays on row 0
      add_read(0, COLUMNS - 1);

      // random: mostly text lines ending in CR/LF, with reads, edits and noise
      counted_items = 0;
      drain_pending = 1'b1;
      next_drain_at = DRAIN_EVERY;
      while (counted_items < RANDOM_ITEMS) begin
         if (counted_items >= next_drain_at) begin
            drain_pending = 1'b1;
            next_drain_at += DRAIN_EVERY;
         end
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 19);
               if (r == 0) add_put(tcw_pkg::CHAR_TAB);
               else if (r == 1) add_put(tcw_pkg::CHAR_BS);
               else add_put(CHAR_W'($urandom_range(tcw_pkg::CHAR_BLANK, CHAR_LAST)));
            end
            tail = $urandom_range(0, 9);
            if (tail < 6) add_put(tcw_pkg::CHAR_CR);
            if (tail < 9) add_put(tcw_pkg::CHAR_LF);
         end else if (sel < 70) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0) add_read($urandom_range(0, 31), $urandom_range(0, 127));
               else add_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
            end
         end else if (sel < 80) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) add_put(tcw_pkg::CHAR_BS);
         end else if (sel < 88) begin
            add_put(CHAR_W'($urandom));
         end else if (sel < 91) begin
            add_item(tcw_pkg::ACT_CLEAR, CHAR_W'($urandom), ROW_FIELD_W'($urandom),
                     COL_FIELD_W'($urandom));
         end else if (sel < 96) begin
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++) add_put(tcw_pkg::CHAR_LF);
         end else begin
            add_item(ACTION_W'($urandom), CHAR_W'($urandom), ROW_FIELD_W'($urandom),
                     COL_FIELD_W'($urandom));
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_q.size() != 0 || req_valid || cursor_expect_q.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d puts, %0d reads, %0d clears, %0d unused-action beats",
               put_count, read_count, clear_count, odd_count);
      $display("screen scrolled %0d times; %0d results checked, %0d mismatches",
               scroll_count, result_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[text_console_writer_top.f]
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer_top.sv
design/tcw_checker.sv
test/tb_text_console_writer_top.sv
